[src/nsme_pkg.sv]
`timescale 1ns / 1ps
package nsme_pkg;

    // Input item kinds carried in s_tuser.
    typedef enum logic [1:0] {
        OP_NOTE  = 2'd0,
        OP_FRAME = 2'd1,
        OP_PEAK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic CFG_NOTE_BASE = 1'b0;
    localparam logic CFG_MAX_VEL   = 1'b1;

    // MIDI status bytes, channel 0.
    localparam logic [7:0] STATUS_ON  = 8'h90;
    localparam logic [7:0] STATUS_OFF = 8'h80;

    // Log2 result format: signed, 16 fraction bits.
    localparam int LOG_FRAC = 16;
    localparam int LOG_W    = 23;
    localparam int PROD_W   = 30;

    localparam logic [6:0] VEL_MAX = 7'd127;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_NORM,
        BK_SQ,
        BK_LOGDONE,
        BK_MUL,
        BK_DIVCHK,
        BK_DIV,
        BK_EMIT,
        BK_SCAN
    } bk_state_t;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[src/nsme_queue.sv]
`timescale 1ns / 1ps
module nsme_queue #(
    parameter int WIDTH = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      head_data,
    output nsme_pkg::q_stat_t     stat
);
    import nsme_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    // Two-entry queue between the front and back parts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data  = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
endmodule

[src/nsme_front.sv]
`timescale 1ns / 1ps
module nsme_front #(
    parameter int NOTE_SPAN     = 64,
    parameter int AMP_FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_op,
    input  logic [6:0]                  in_note,
    input  logic [31:0]                 in_amp,
    input  logic [6:0]                  note_base,
    input  nsme_pkg::q_stat_t           q_stat,
    output logic                        q_push,
    output logic [NOTE_SPAN+71:0]       q_data
);
    import nsme_pkg::*;

    localparam int IW = (NOTE_SPAN > 1) ? $clog2(NOTE_SPAN) : 1;
    localparam logic [31:0] PEAK_RESET = 32'(((64'd1 << AMP_FRAC_BITS) + 64'd5) / 64'd10);

    logic [NOTE_SPAN-1:0] prev_reg, prev_next;
    logic [NOTE_SPAN-1:0] cur_reg, cur_next;
    logic [31:0]          peak_reg, peak_next;

    logic                 accept;
    logic [7:0]           rel;
    logic                 in_win;
    logic [NOTE_SPAN-1:0] bit_sel;
    logic [NOTE_SPAN-1:0] key_ok;
    logic [NOTE_SPAN-1:0] gone;
    logic [31:0]          new_peak;

    assign in_ready = ~q_stat.full;
    assign accept   = in_valid & in_ready;

    // Window check and the set bit of the event.
    assign rel     = {1'b0, in_note} - {1'b0, note_base};
    assign in_win  = (in_note >= note_base) && (rel < 8'(NOTE_SPAN));
    assign bit_sel = NOTE_SPAN'(1) << rel[IW-1:0];
    assign new_peak = (in_amp > peak_reg) ? in_amp : peak_reg;

    // Notes whose key stays within the MIDI range under the current base.
    always_comb begin
        for (int i = 0; i < NOTE_SPAN; i++) begin
            key_ok[i] = ({1'b0, note_base} + 8'(i)) <= 8'd127;
        end
    end
    assign gone = prev_reg & ~cur_reg & key_ok;

    // Classify the item, update the sets and the peak, and queue work.
    always_comb begin
        prev_next = prev_reg;
        cur_next  = cur_reg;
        peak_next = peak_reg;
        q_push    = 1'b0;
        q_data    = {gone, new_peak, in_amp, in_note, 1'b0};
        if (accept) begin
            case (op_t'(in_op))
                OP_NOTE: begin
                    if (in_win) begin
                        cur_next  = cur_reg | bit_sel;
                        peak_next = new_peak;
                        q_push    = ((prev_reg & bit_sel) == '0);
                        q_data    = {gone, new_peak, in_amp, in_note, 1'b1};
                    end
                end
                OP_FRAME: begin
                    prev_next = cur_reg;
                    cur_next  = '0;
                    q_push    = (gone != '0);
                    q_data    = {gone, new_peak, in_amp, in_note, 1'b0};
                end
                OP_PEAK: begin
                    peak_next = PEAK_RESET;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            cur_reg  <= '0;
            peak_reg <= PEAK_RESET;
        end else begin
            prev_reg <= prev_next;
            cur_reg  <= cur_next;
            peak_reg <= peak_next;
        end
    end
endmodule

[src/nsme_back.sv]
`timescale 1ns / 1ps
module nsme_back #(
    parameter int NOTE_SPAN     = 64,
    parameter int AMP_FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  nsme_pkg::q_stat_t           q_stat,
    input  logic [NOTE_SPAN+71:0]       q_data,
    output logic                        q_pop,
    input  logic [6:0]                  note_base,
    input  logic [6:0]                  max_velocity,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_status,
    output logic [6:0]                  out_key,
    output logic [6:0]                  out_vel,
    output logic                        out_last
);
    import nsme_pkg::*;

    localparam int IW = (NOTE_SPAN > 1) ? $clog2(NOTE_SPAN) : 1;
    localparam logic [LOG_W-1:0] FRAC_OFS = LOG_W'(AMP_FRAC_BITS) << LOG_FRAC;

    bk_state_t            state_reg, state_next;
    logic [6:0]           note_reg, note_next;
    logic [31:0]          peak_reg, peak_next;
    logic [31:0]          x_reg, x_next;
    logic [31:0]          m_reg, m_next;
    logic [4:0]           p_reg, p_next;
    logic [15:0]          frac_reg, frac_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 which_reg, which_next;
    logic [LOG_W-1:0]     la_reg, la_next;
    logic [LOG_W-1:0]     num_reg, num_next;
    logic [LOG_W-1:0]     den_reg, den_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [2:0]           k_reg, k_next;
    logic [6:0]           vel_reg, vel_next;
    logic [NOTE_SPAN-1:0] gone_reg, gone_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 ovalid_reg, ovalid_next;
    logic [7:0]           ostatus_reg, ostatus_next;
    logic [6:0]           okey_reg, okey_next;
    logic [6:0]           ovel_reg, ovel_next;
    logic                 olast_reg, olast_next;

    logic                 out_free;
    logic [4:0]           lead;
    logic [63:0]          sq;
    logic [32:0]          sq_hi;
    logic [LOG_W-1:0]     lval;
    logic [PROD_W-1:0]    div_d;

    // Position of the leading one of the value under conversion.
    always_comb begin
        lead = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (x_reg[i]) begin
                lead = 5'(i);
            end
        end
    end

    assign sq      = 64'(m_reg) * 64'(m_reg);
    assign sq_hi   = sq[63:31];
    assign lval    = LOG_W'({p_reg, frac_reg}) - FRAC_OFS;
    assign div_d   = PROD_W'(den_reg) << k_reg;
    assign out_free = ~ovalid_reg | out_ready;

    // Sequencer: two log2 conversions, scaling, a short divide, or a note-off scan.
    always_comb begin
        state_next   = state_reg;
        note_next    = note_reg;
        peak_next    = peak_reg;
        x_next       = x_reg;
        m_next       = m_reg;
        p_next       = p_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        which_next   = which_reg;
        la_next      = la_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        k_next       = k_reg;
        vel_next     = vel_reg;
        gone_next    = gone_reg;
        idx_next     = idx_reg;
        ovalid_next  = ovalid_reg & ~out_ready;
        ostatus_next = ostatus_reg;
        okey_next    = okey_reg;
        ovel_next    = ovel_reg;
        olast_next   = olast_reg;
        q_pop        = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop     = 1'b1;
                    note_next = q_data[7:1];
                    peak_next = q_data[71:40];
                    x_next    = q_data[39:8];
                    gone_next = q_data[NOTE_SPAN+71:72];
                    idx_next  = '0;
                    which_next = 1'b0;
                    if (!q_data[0]) begin
                        state_next = BK_SCAN;
                    end else if (q_data[39:8] == '0 || q_data[71:40] == '0) begin
                        vel_next   = VEL_MAX;
                        state_next = BK_EMIT;
                    end else begin
                        state_next = BK_NORM;
                    end
                end
            end
            BK_NORM: begin
                p_next     = lead;
                m_next     = x_reg << (5'd31 - lead);
                frac_next  = '0;
                cnt_next   = '0;
                state_next = BK_SQ;
            end
            BK_SQ: begin
                // One fraction bit per squaring of the mantissa.
                if (sq_hi[32]) begin
                    m_next    = sq_hi[32:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end else begin
                    m_next    = sq_hi[31:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = BK_LOGDONE;
                end
            end
            BK_LOGDONE: begin
                if (!which_reg) begin
                    la_next    = lval;
                    x_next     = peak_reg;
                    which_next = 1'b1;
                    state_next = BK_NORM;
                end else if (lval == '0) begin
                    vel_next   = VEL_MAX;
                    state_next = BK_EMIT;
                end else if (la_reg == '0 || (la_reg[LOG_W-1] != lval[LOG_W-1])) begin
                    vel_next   = '0;
                    state_next = BK_EMIT;
                end else begin
                    num_next   = la_reg[LOG_W-1] ? (~la_reg + 1'b1) : la_reg;
                    den_next   = lval[LOG_W-1] ? (~lval + 1'b1) : lval;
                    state_next = BK_MUL;
                end
            end
            BK_MUL: begin
                rem_next   = PROD_W'(num_reg) * PROD_W'(max_velocity);
                state_next = BK_DIVCHK;
            end
            BK_DIVCHK: begin
                // A quotient of 128 or more clamps to the top velocity.
                k_next   = 3'd6;
                vel_next = '0;
                if (rem_reg >= (PROD_W'(den_reg) << 7)) begin
                    vel_next   = VEL_MAX;
                    state_next = BK_EMIT;
                end else begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (rem_reg >= div_d) begin
                    rem_next = rem_reg - div_d;
                    vel_next = vel_reg | (7'd1 << k_reg);
                end
                k_next = k_reg - 3'd1;
                if (k_reg == 3'd0) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    ovalid_next  = 1'b1;
                    ostatus_next = STATUS_ON;
                    okey_next    = note_reg;
                    ovel_next    = vel_reg;
                    olast_next   = 1'b1;
                    state_next   = BK_IDLE;
                end
            end
            BK_SCAN: begin
                // Walk the gone set upward, one note a cycle; a set note waits while the output holds a message.
                if (gone_reg == '0) begin
                    state_next = BK_IDLE;
                end else if (!gone_reg[0] || out_free) begin
                    if (gone_reg[0]) begin
                        ovalid_next  = 1'b1;
                        ostatus_next = STATUS_OFF;
                        okey_next    = 7'(8'(note_base) + 8'(idx_reg));
                        ovel_next    = '0;
                        olast_next   = ((gone_reg >> 1) == '0);
                    end
                    gone_next = gone_reg >> 1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        note_reg    <= note_next;
        peak_reg    <= peak_next;
        x_reg       <= x_next;
        m_reg       <= m_next;
        p_reg       <= p_next;
        frac_reg    <= frac_next;
        cnt_reg     <= cnt_next;
        which_reg   <= which_next;
        la_reg      <= la_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        k_reg       <= k_next;
        vel_reg     <= vel_next;
        gone_reg    <= gone_next;
        idx_reg     <= idx_next;
        ostatus_reg <= ostatus_next;
        okey_reg    <= okey_next;
        ovel_reg    <= ovel_next;
        olast_reg   <= olast_next;
    end

    assign out_valid  = ovalid_reg;
    assign out_status = ostatus_reg;
    assign out_key    = okey_reg;
    assign out_vel    = ovel_reg;
    assign out_last   = olast_reg;
endmodule

[src/note_set_to_midi_events_core.sv]
`timescale 1ns / 1ps
// A note-on beat passes the queue pop, two log2 conversions on one squaring multiplier,
// a scaling multiply, a range check and a 7-step divide before its note-on is emitted.
// The back part pops a new beat once done with the last; a frame-end beat emits one note-off
// per cycle while the output is free. Beats are accepted while the two-entry queue has room.
// Reset (synchronous, aresetn low) clears both note sets, sets the peak to 0.1,
// note_base to 28 and max_velocity to 127.
module note_set_to_midi_events_core #(
    parameter int NOTE_SPAN     = 64,
    parameter int AMP_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // note_number[6:0], amplitude[38:7]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status_byte[7:0], key[14:8], velocity[21:15]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    import nsme_pkg::*;

    localparam int QW = NOTE_SPAN + 72;

    logic [6:0]    note_base_reg;
    logic [6:0]    max_vel_reg;
    logic          q_push, q_pop;
    logic [QW-1:0] q_in, q_head;
    q_stat_t       q_stat;
    logic [7:0]    o_status;
    logic [6:0]    o_key, o_vel;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_base_reg <= 7'd28;
            max_vel_reg   <= 7'd127;
        end else if (cfg_we) begin
            if (cfg_index == CFG_NOTE_BASE) begin
                note_base_reg <= cfg_data;
            end else if (cfg_index == CFG_MAX_VEL) begin
                max_vel_reg <= cfg_data;
            end
        end
    end

    nsme_front #(.NOTE_SPAN(NOTE_SPAN), .AMP_FRAC_BITS(AMP_FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_note   (s_tdata[6:0]),
        .in_amp    (s_tdata[38:7]),
        .note_base (note_base_reg),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    nsme_queue #(.WIDTH(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head_data (q_head),
        .stat      (q_stat)
    );

    nsme_back #(.NOTE_SPAN(NOTE_SPAN), .AMP_FRAC_BITS(AMP_FRAC_BITS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .q_data       (q_head),
        .q_pop        (q_pop),
        .note_base    (note_base_reg),
        .max_velocity (max_vel_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (o_status),
        .out_key      (o_key),
        .out_vel      (o_vel),
        .out_last     (m_tlast)
    );

    assign m_tdata = {2'b00, o_vel, o_key, o_status};
endmodule

[bench/note_set_to_midi_events_core_test.sv]
`timescale 1ns / 1ps
module note_set_to_midi_events_core_test;
    import nsme_pkg::*;

    localparam int SPAN = 64;
    localparam int FRAC = 16;
    localparam logic [31:0] PEAK_INIT = 32'd6554;

    typedef struct packed {
        op_t         op;
        logic [6:0]  note;
        logic [31:0] amp;
    } beat_t;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] key;
        logic [6:0] vel;
        logic       last;
    } midi_msg_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data = '0;

    note_set_to_midi_events_core dut (.*);

    always #2 aclk = ~aclk;

    // Predictor state and the messages it expects.
    logic [63:0] prev_set, cur_set;
    logic [31:0] peak;
    logic [6:0]  base_reg, vmax_reg;
    beat_t       pending_beats[$];
    midi_msg_t   expected_msgs[$];
    int          errors = 0;
    bit          hold_off = 1'b0;

    // Fixed-point log2 with 16 fraction bits, offset by the amplitude format.
    function automatic longint log2_fixed(logic [31:0] x);
        int          p;
        logic [63:0] m;
        logic [31:0] f;
        p = 31;
        f = 0;
        while (p > 0 && x[p] == 1'b0) p--;
        m = 64'(x) << (31 - p);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= 64'h1_0000_0000) begin
                f[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (longint'(p) <<< 16) + longint'(f) - (longint'(FRAC) <<< 16);
    endfunction

    function automatic logic [6:0] velocity_for(logic [31:0] a, logic [31:0] pk);
        longint la, lp, v;
        if (a == 0 || pk == 0) return 7'd127;
        la = log2_fixed(a);
        lp = log2_fixed(pk);
        if (lp == 0) return 7'd127;
        if (la == 0) return 7'd0;
        if ((la < 0) != (lp < 0)) return 7'd0;
        if (la < 0) la = -la;
        if (lp < 0) lp = -lp;
        v = (la * longint'(vmax_reg)) / lp;
        return v > 127 ? 7'd127 : 7'(v);
    endfunction

    // Works out the messages one beat causes and updates the note sets.
    task automatic predict_messages(beat_t b);
        int          idx, key, n;
        logic [63:0] gone;
        midi_msg_t   msg;
        case (b.op)
            OP_NOTE: begin
                idx = int'(b.note) - int'(base_reg);
                if (idx >= 0 && idx < SPAN) begin
                    cur_set[idx] = 1'b1;
                    if (b.amp > peak) peak = b.amp;
                    if (!prev_set[idx]) begin
                        msg = '{STATUS_ON, b.note, velocity_for(b.amp, peak), 1'b1};
                        expected_msgs.push_back(msg);
                    end
                end
            end
            OP_FRAME: begin
                gone = prev_set & ~cur_set;
                n = 0;
                for (int i = 0; i < SPAN; i++) begin
                    key = int'(base_reg) + i;
                    if (gone[i] && key <= 127) begin
                        msg = '{STATUS_OFF, 7'(key), 7'd0, 1'b0};
                        expected_msgs.push_back(msg);
                        n++;
                    end
                end
                if (n > 0) expected_msgs[$].last = 1'b1;
                prev_set = cur_set;
                cur_set = '0;
            end
            OP_PEAK: peak = PEAK_INIT;
            default: ;
        endcase
    endtask

    // Sender: offers queued beats with random gaps.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_messages(beat_t'({s_tuser, s_tdata[6:0], s_tdata[38:7]}));
                void'(pending_beats.pop_front());
                send_gap <= $urandom_range(0, 5);
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat
            end else if (pending_beats.size() > 0 &&
                         (send_gap == 0 || (s_tvalid && s_tready && $urandom_range(0, 2) == 0))) begin
                beat_t nb;
                nb = pending_beats[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, nb.amp, nb.note};
                s_tuser  <= nb.op;
            end else begin
                s_tvalid <= 1'b0;
                if (send_gap > 0 && !(s_tvalid && s_tready)) send_gap <= send_gap - 1;
            end
        end
    end

    // Receiver: random stalls, a long hold-off on request, and checking.
    int recv_gap = 0;
    always @(posedge aclk) begin
        midi_msg_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_msgs.size() == 0) begin
                    $error("unexpected message %h last %b", m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_msgs.pop_front();
                    if (m_tdata[7:0] != want.status) begin
                        $error("status_byte expected %h actual %h", want.status, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[14:8] != want.key) begin
                        $error("key expected %0d actual %0d", want.key, m_tdata[14:8]);
                        errors++;
                    end
                    if (m_tdata[21:15] != want.vel) begin
                        $error("velocity expected %0d actual %0d", want.vel, m_tdata[21:15]);
                        errors++;
                    end
                    if (m_tlast != want.last) begin
                        $error("last expected %b actual %b", want.last, m_tlast);
                        errors++;
                    end
                end
                recv_gap <= $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else if (hold_off) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic beat_t note_beat(int note, logic [31:0] amp);
        return '{OP_NOTE, 7'(note), amp};
    endfunction

    function automatic logic [31:0] rand_amp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0000_FFFF);
            2: return $urandom_range(32'h0001_0000, 32'h000F_FFFF);
            3: return 32'h0001_0000;
            default: return $urandom_range(1, 32'h0004_0000);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_tvalid || expected_msgs.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_NOTE_BASE) base_reg = val;
        else vmax_reg = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random frames: a few notes mostly near the window, at times a peak or idle beat, then frame end.
    task automatic random_frames(int items);
        int sent, k, lo;
        sent = 0;
        while (sent < items) begin
            k = $urandom_range(0, 6);
            for (int i = 0; i < k; i++) begin
                lo = int'(base_reg);
                if ($urandom_range(0, 7) == 0)
                    pending_beats.push_back(note_beat($urandom_range(0, 127), rand_amp()));
                else
                    pending_beats.push_back(note_beat(
                        (lo + $urandom_range(0, 15)) & 127, rand_amp()));
                sent++;
            end
            case ($urandom_range(0, 15))
                0: pending_beats.push_back('{OP_PEAK, 7'($urandom), $urandom});
                1: pending_beats.push_back('{OP_NONE, 7'($urandom), $urandom});
                default: ;
            endcase
            pending_beats.push_back('{OP_FRAME, 7'($urandom), $urandom});
            sent++;
        end
    endtask

    initial begin
        prev_set = '0;
        cur_set  = '0;
        peak     = PEAK_INIT;
        base_reg = 7'd28;
        vmax_reg = 7'd127;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: window edges, amplitude extremes, peak cases, frame ends.
        pending_beats.push_back(note_beat(28, 32'h0001_0000));
        pending_beats.push_back(note_beat(91, 32'hFFFF_FFFF));
        pending_beats.push_back(note_beat(27, 32'h0005_0000));
        pending_beats.push_back(note_beat(92, 32'h0005_0000));
        pending_beats.push_back(note_beat(40, 32'd0));
        pending_beats.push_back(note_beat(40, 32'd1));
        pending_beats.push_back('{OP_FRAME, 7'd0, 32'd0});
        pending_beats.push_back(note_beat(28, 32'h0000_8000));
        pending_beats.push_back(note_beat(50, 32'h0000_1000));
        pending_beats.push_back('{OP_PEAK, 7'h7F, 32'hFFFF_FFFF});
        pending_beats.push_back(note_beat(51, 32'h0001_0000));
        pending_beats.push_back(note_beat(52, 32'h0000_0100));
        pending_beats.push_back('{OP_NONE, 7'h7F, 32'hFFFF_FFFF});
        pending_beats.push_back('{OP_FRAME, 7'h7F, 32'hFFFF_FFFF});
        pending_beats.push_back('{OP_FRAME, 7'd0, 32'd0});
        pending_beats.push_back('{OP_FRAME, 7'd0, 32'd0});
        wait_idle();

        // Peak of exactly 1.0 gives a zero denominator.
        write_reg(CFG_MAX_VEL, 7'd0);
        pending_beats.push_back(note_beat(60, 32'h0000_4000));
        pending_beats.push_back('{OP_PEAK, 7'd0, 32'd0});
        wait_idle();
        write_reg(CFG_MAX_VEL, 7'd100);
        pending_beats.push_back(note_beat(30, 32'h0001_0000));
        pending_beats.push_back(note_beat(31, 32'h0000_4000));
        // Fill the window so a later base shift moves the note-offs up to key 127.
        for (int i = 0; i < 64; i += 3)
            pending_beats.push_back(note_beat(28 + i, 32'h0002_0000));
        pending_beats.push_back('{OP_FRAME, 7'd0, 32'd0});
        wait_idle();
        write_reg(CFG_NOTE_BASE, 7'd64);
        pending_beats.push_back('{OP_FRAME, 7'd0, 32'd0});
        wait_idle();

        // Long receiver hold-off while the sender keeps offering beats.
        hold_off = 1'b1;
        random_frames(30);
        repeat (400) @(posedge aclk);
        hold_off = 0;
        wait_idle();

        write_reg(CFG_NOTE_BASE, 7'd0);
        write_reg(CFG_MAX_VEL, 7'd127);
        random_frames(70);
        wait_idle();
        write_reg(CFG_NOTE_BASE, 7'($urandom_range(0, 64)));
        write_reg(CFG_MAX_VEL, 7'($urandom_range(1, 126)));
        random_frames(60);
        wait_idle();
        write_reg(CFG_NOTE_BASE, 7'd28);
        write_reg(CFG_MAX_VEL, 7'd127);
        random_frames(60);
        wait_idle();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
